// ===== sv/pixel_field_bit_packer_macros.svh =====
// Assertion macros shared by the pixel field bit packer.
`ifndef PIXEL_FIELD_BIT_PACKER_MACROS_SVH
`define PIXEL_FIELD_BIT_PACKER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define PFBP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define PFBP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pfbp_pkg.sv =====
// Types and constants shared by the pixel field bit packer modules.
package pfbp_pkg;

    localparam int NUM_SLOTS  = 8;
    localparam int SLOT_IDX_W = 3;
    localparam int SIZE_W     = 5;
    localparam int CHAN_SEL_W = 2;
    localparam int COUNT_W    = 4;
    localparam int CHAN_W     = 16;
    localparam int ACC_W      = 23;
    localparam int HELD_W     = 5;
    localparam int REM_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    localparam logic [HELD_W-1:0] BYTE_BITS = 5'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_SIZES    = 2'd2;

    // Channel selector codes
    localparam logic [CHAN_SEL_W-1:0] CH_RED   = 2'd0;
    localparam logic [CHAN_SEL_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CHAN_SEL_W-1:0] CH_BLUE  = 2'd2;
    localparam logic [CHAN_SEL_W-1:0] CH_ALPHA = 2'd3;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              last_pixel;
    } t_pixel;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_of_run;
        logic       end_of_image;
    } t_byte_out;

    typedef struct packed {
        logic [COUNT_W-1:0]                    count;
        logic [NUM_SLOTS-1:0][CHAN_SEL_W-1:0]  chans;
        logic [NUM_SLOTS-1:0][SIZE_W-1:0]      sizes;
        logic [REM_W-1:0]                      size_sum;
    } t_cfg_view;

    typedef struct packed {
        logic                  busy;
        logic                  load;
        logic                  append;
        logic                  emit;
        logic                  flush;
        logic [SLOT_IDX_W-1:0] slot;
        logic                  last_of_run;
        logic                  end_of_image;
    } t_cmd;

    typedef struct packed {
        logic [HELD_W-1:0] held;
        logic              can_load;
        logic              last;
    } t_sts;

endpackage

// ===== sv/pfbp_cfg.sv =====
// Configuration registers with clamped field count, clamped sizes and their sum.
module pfbp_cfg #(
    parameter int MAX_FIELDS   = 8,
    parameter int CHANNEL_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pfbp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pfbp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output pfbp_pkg::t_cfg_view                 o_view
);

    localparam logic [pfbp_pkg::COUNT_W-1:0] MAX_CNT  = pfbp_pkg::COUNT_W'(MAX_FIELDS);
    localparam logic [pfbp_pkg::SIZE_W-1:0]  MAX_SIZE = pfbp_pkg::SIZE_W'(CHANNEL_BITS);

    logic [pfbp_pkg::COUNT_W-1:0]                   r_field_count;
    logic [pfbp_pkg::NUM_SLOTS*pfbp_pkg::CHAN_SEL_W-1:0] r_field_channels;
    logic [pfbp_pkg::CFG_DATA_W-1:0]                r_field_sizes;

    // refuse writes while reset is held
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_count    <= 4'd1;
            r_field_channels <= '0;
            r_field_sizes    <= 40'd16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pfbp_pkg::CFG_FIELD_COUNT: begin
                    r_field_count <= i_cfg_data[pfbp_pkg::COUNT_W-1:0];
                end
                pfbp_pkg::CFG_FIELD_CHANNELS: begin
                    r_field_channels <= i_cfg_data[pfbp_pkg::NUM_SLOTS*pfbp_pkg::CHAN_SEL_W-1:0];
                end
                pfbp_pkg::CFG_FIELD_SIZES: begin
                    r_field_sizes <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        logic [pfbp_pkg::SIZE_W-1:0] raw;
        logic [pfbp_pkg::REM_W-1:0]  sum;
        o_view = '0;
        sum    = '0;
        if (r_field_count == '0) begin
            o_view.count = 4'd1;
        end else if (r_field_count > MAX_CNT) begin
            o_view.count = MAX_CNT;
        end else begin
            o_view.count = r_field_count;
        end
        for (int k = 0; k < pfbp_pkg::NUM_SLOTS; k++) begin
            o_view.chans[k] = r_field_channels[pfbp_pkg::CHAN_SEL_W*k +: pfbp_pkg::CHAN_SEL_W];
            raw = r_field_sizes[pfbp_pkg::SIZE_W*k +: pfbp_pkg::SIZE_W];
            if (raw == '0) begin
                o_view.sizes[k] = 5'd1;
            end else if (raw > MAX_SIZE) begin
                o_view.sizes[k] = MAX_SIZE;
            end else begin
                o_view.sizes[k] = raw;
            end
            if (pfbp_pkg::COUNT_W'(k) < o_view.count) begin
                sum = sum + pfbp_pkg::REM_W'(o_view.sizes[k]);
            end
        end
        o_view.size_sum = sum;
    end

endmodule

// ===== sv/pfbp_ctrl.sv =====
// Controller: sequences field appends, byte emits and the final flush of one pixel.
module pfbp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pfbp_pkg::t_cfg_view  i_view,
    input  pfbp_pkg::t_sts       i_sts,
    output pfbp_pkg::t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state                          r_state, n_state;
    logic [pfbp_pkg::COUNT_W-1:0]    r_fidx, n_fidx;
    logic [pfbp_pkg::REM_W-1:0]      r_rem, n_rem;

    logic ge_byte;
    logic fields_left;

    assign ge_byte     = i_sts.held >= pfbp_pkg::BYTE_BITS;
    assign fields_left = r_fidx < i_view.count;
    // hold the input off while reset is asserted
    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;

    always_comb begin
        n_state = r_state;
        n_fidx  = r_fidx;
        n_rem   = r_rem;
        o_cmd   = '0;
        o_cmd.busy = (r_state == S_RUN);
        o_cmd.slot = r_fidx[pfbp_pkg::SLOT_IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_fidx  = '0;
                    n_rem   = pfbp_pkg::REM_W'(i_sts.held) + i_view.size_sum;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                priority if (ge_byte) begin
                    if (i_sts.can_load) begin
                        o_cmd.emit = 1'b1;
                        // last of run when no full byte and no flush follows
                        o_cmd.last_of_run = (r_rem == 8'd8) || (r_rem < 8'd16 && !i_sts.last);
                        o_cmd.end_of_image = o_cmd.last_of_run && i_sts.last;
                        n_rem = r_rem - 8'd8;
                    end
                end else if (fields_left) begin
                    o_cmd.append = 1'b1;
                    n_fidx = r_fidx + 4'd1;
                end else if (i_sts.last && i_sts.held != '0) begin
                    if (i_sts.can_load) begin
                        o_cmd.flush        = 1'b1;
                        o_cmd.last_of_run  = 1'b1;
                        o_cmd.end_of_image = 1'b1;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fidx  <= '0;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            r_fidx  <= n_fidx;
            r_rem   <= n_rem;
        end
    end

endmodule

// ===== sv/pfbp_dpath.sv =====
// Datapath: pixel register, bit accumulator and output byte register.
module pfbp_dpath #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pfbp_pkg::t_pixel     i_in,
    input  pfbp_pkg::t_cfg_view  i_view,
    input  pfbp_pkg::t_cmd       i_cmd,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output pfbp_pkg::t_byte_out  o_out,
    output pfbp_pkg::t_sts       o_sts
);

    localparam logic [pfbp_pkg::CHAN_W-1:0] CHAN_MASK =
        pfbp_pkg::CHAN_W'((32'd1 << CHANNEL_BITS) - 32'd1);
    localparam logic [pfbp_pkg::SIZE_W-1:0] CHAN_SIZE = pfbp_pkg::SIZE_W'(CHANNEL_BITS);

    pfbp_pkg::t_pixel              r_pix;
    logic [pfbp_pkg::ACC_W-1:0]    r_acc, n_acc;
    logic [pfbp_pkg::HELD_W-1:0]   r_held, n_held;
    logic                          r_out_valid;
    pfbp_pkg::t_byte_out           r_out;

    logic [pfbp_pkg::CHAN_W-1:0]   chan;
    logic [pfbp_pkg::CHAN_W-1:0]   field_val;
    logic [pfbp_pkg::SIZE_W-1:0]   size;
    logic [pfbp_pkg::ACC_W-1:0]    acc_down;
    logic [3:0]                    pad_shift;
    logic [7:0]                    pad_byte;
    logic [7:0]                    out_byte;
    logic                          can_load;

    always_comb begin
        chan = r_pix.red;
        unique case (i_view.chans[i_cmd.slot])
            pfbp_pkg::CH_RED:   chan = r_pix.red;
            pfbp_pkg::CH_GREEN: chan = r_pix.green;
            pfbp_pkg::CH_BLUE:  chan = r_pix.blue;
            pfbp_pkg::CH_ALPHA: chan = r_pix.alpha;
            default:            chan = r_pix.red;
        endcase
    end

    // top size bits of the channel, right aligned
    assign size      = i_view.sizes[i_cmd.slot];
    assign field_val = (chan & CHAN_MASK) >> (CHAN_SIZE - size);

    assign acc_down  = r_acc >> (r_held - pfbp_pkg::BYTE_BITS);
    assign pad_shift = 4'd8 - {1'b0, r_held[2:0]};
    assign pad_byte  = r_acc[7:0] << pad_shift;
    assign out_byte  = i_cmd.flush ? pad_byte : acc_down[7:0];

    assign can_load  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_acc  = r_acc;
        n_held = r_held;
        if (i_cmd.append) begin
            n_acc  = (r_acc << size) | pfbp_pkg::ACC_W'(field_val);
            n_held = r_held + pfbp_pkg::HELD_W'(size);
        end else if (i_cmd.emit) begin
            n_held = r_held - pfbp_pkg::BYTE_BITS;
        end else if (i_cmd.flush) begin
            n_held = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix <= i_in;
        end
        r_acc <= n_acc;
        if (i_cmd.emit || i_cmd.flush) begin
            r_out.packed_byte  <= out_byte;
            r_out.last_of_run  <= i_cmd.last_of_run;
            r_out.end_of_image <= i_cmd.end_of_image;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_held <= n_held;
            if (i_cmd.emit || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out          = r_out;
    assign o_sts.held     = r_held;
    assign o_sts.can_load = can_load;
    assign o_sts.last     = r_pix.last_pixel;

endmodule

// ===== sv/pixel_field_bit_packer.sv =====
// Pixel field bit packer: packs the top bits of configured RGBA channels, MSB first, into
// a byte stream that runs across pixels; on a pixel marked last, a partial byte is flushed
// with zero padding and the stream restarts empty. One pixel at a time: after a pixel is
// taken the input stays stalled while the controller appends each field, emitting each
// completed byte (and the flush) before the next append once the output register can take
// it, and then returns to idle, where the next pixel is taken. A byte that waits on a
// stalled output register holds the pixel up. An output register holds each byte; a byte
// is loaded into it when it is empty or being taken in the same cycle. Configuration must
// be written only when idle; the block does not enforce this. The config port is ready
// whenever reset is released. No clearing pass after reset.
`include "pixel_field_bit_packer_macros.svh"

module pixel_field_bit_packer #(
    parameter int MAX_FIELDS   = 8,
    parameter int CHANNEL_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  pfbp_pkg::t_pixel                 i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output pfbp_pkg::t_byte_out              o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pfbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pfbp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    pfbp_pkg::t_cfg_view s_view;
    pfbp_pkg::t_cmd      s_cmd;
    pfbp_pkg::t_sts      s_sts;

    pfbp_cfg #(
        .MAX_FIELDS   (MAX_FIELDS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_view      (s_view)
    );

    pfbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_view     (s_view),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    pfbp_dpath #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_view      (s_view),
        .i_cmd       (s_cmd),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .o_sts       (s_sts)
    );

    `PFBP_ASSERT_IMP(a_eoi_on_last_byte, o_out_valid && o_out.end_of_image, o_out.last_of_run, "end of image on a byte that is not last of run")
    `PFBP_ASSERT_IMP(a_byte_has_room, s_cmd.emit || s_cmd.flush, s_sts.can_load, "byte formed while output register is blocked")
    `PFBP_ASSERT_IMP(a_idle_partial_only, !s_cmd.busy, s_sts.held < pfbp_pkg::BYTE_BITS, "full byte left behind when idle")
    `PFBP_ASSERT_IMP(a_last_pixel_empties, $fell(s_cmd.busy) && s_sts.last, s_sts.held == '0, "bits held after a last pixel")

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the pixel field bit packer: predicts packed bytes per pixel.
import pfbp_pkg::*;

class packed_byte_scoreboard;
    logic [COUNT_W-1:0]            field_count;
    logic [2*NUM_SLOTS-1:0]        field_channels;
    logic [SIZE_W*NUM_SLOTS-1:0]   field_sizes;
    logic [7:0]                    partial;
    int unsigned                   held_bits;
    t_byte_out                     expected_bytes[$];
    int unsigned                   errors;

    function new();
        field_count    = COUNT_W'(1);
        field_channels = '0;
        field_sizes    = (SIZE_W*NUM_SLOTS)'(16);
        partial        = '0;
        held_bits      = 0;
        errors         = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FIELD_COUNT:    field_count = data[COUNT_W-1:0];
            CFG_FIELD_CHANNELS: field_channels = data[2*NUM_SLOTS-1:0];
            CFG_FIELD_SIZES:    field_sizes = data[SIZE_W*NUM_SLOTS-1:0];
            default: ;
        endcase
    endfunction

    // Append the configured fields of one pixel to the stream; queue every byte completed.
    function void note_pixel(t_pixel px);
        logic [CHAN_W-1:0] chan [4];
        logic [CHAN_W-1:0] val;
        logic [7:0]        run [$];
        int unsigned       n_fields;
        int unsigned       width;
        t_byte_out         b;

        chan[0] = px.red;
        chan[1] = px.green;
        chan[2] = px.blue;
        chan[3] = px.alpha;
        if (field_count == 0) n_fields = 1;
        else if (field_count > NUM_SLOTS) n_fields = NUM_SLOTS;
        else n_fields = field_count;

        for (int k = 0; k < int'(n_fields); k++) begin
            width = field_sizes[SIZE_W*k +: SIZE_W];
            if (width == 0) width = 1;
            else if (width > CHAN_W) width = CHAN_W;
            val = chan[field_channels[2*k +: 2]] >> (CHAN_W - width);
            for (int i = int'(width) - 1; i >= 0; i--) begin
                partial = {partial[6:0], val[i]};
                held_bits++;
                if (held_bits == 8) begin
                    run       = {run, partial};
                    partial   = '0;
                    held_bits = 0;
                end
            end
        end

        // Flush a partial byte, zero padded, and restart the stream empty.
        if (px.last_pixel) begin
            if (held_bits != 0) run = {run, partial << (8 - held_bits)};
            partial   = '0;
            held_bits = 0;
        end

        foreach (run[i]) begin
            b.packed_byte  = run[i];
            b.last_of_run  = (i == run.size() - 1);
            b.end_of_image = (i == run.size() - 1) && px.last_pixel;
            expected_bytes = {expected_bytes, b};
        end
    endfunction

    function void check_byte(t_byte_out got);
        t_byte_out want;

        if (expected_bytes.size() == 0) begin
            $error("unexpected byte: packed_byte %02h last_of_run %0b end_of_image %0b",
                   got.packed_byte, got.last_of_run, got.end_of_image);
            errors++;
            return;
        end
        want = expected_bytes.pop_front();
        if (got.packed_byte !== want.packed_byte) begin
            $error("packed_byte: expected %02h, got %02h", want.packed_byte, got.packed_byte);
            errors++;
        end
        if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
            errors++;
        end
        if (got.end_of_image !== want.end_of_image) begin
            $error("end_of_image: expected %0b, got %0b", want.end_of_image, got.end_of_image);
            errors++;
        end
    endfunction

    function int unsigned pending();
        return expected_bytes.size();
    endfunction
endclass

module tb;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_PIXELS   = 17;

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    t_pixel                 i_in        = '0;
    logic                   i_out_stall = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic                   o_cfg_ready;
    t_byte_out              o_out;

    int unsigned            gap_max     = 0;
    int unsigned            out_wait    = 0;
    int unsigned            idle_cycles = 0;
    packed_byte_scoreboard  sb;

    pixel_field_bit_packer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hold the output stalled for a freshly drawn number of cycles after each accepted byte.
    always @(posedge i_clk) begin : out_pacer
        int unsigned w;
        if (!i_rst_n) begin
            out_wait    <= 0;
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) w = $urandom_range(0, gap_max);
            else if (out_wait != 0) w = out_wait - 1;
            else w = 0;
            out_wait    <= w;
            i_out_stall <= (w != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_pixel(i_in);
            if (o_out_valid && !i_out_stall) sb.check_byte(o_out);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("pixel_field_bit_packer regression: fail");
                $finish;
            end
        end
    end

    function automatic t_pixel make_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                          logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] a,
                                          logic last);
        t_pixel p;
        p.red        = r;
        p.green      = g;
        p.blue       = b;
        p.alpha      = a;
        p.last_pixel = last;
        return p;
    endfunction

    function automatic logic [CHAN_W-1:0] random_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return CHAN_W'(16'h8000);
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    function automatic t_pixel random_pixel();
        return make_pixel(random_channel(), random_channel(), random_channel(),
                          random_channel(), $urandom_range(0, 5) == 0);
    endfunction

    // Idle for a drawn gap, then present the pixel and hold it until accepted.
    task automatic send_pixel(t_pixel px);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= px;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain every expected byte, then give a pixel with no output time to finish.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers: random junk above the count and channel widths, sizes filling the word.
    task automatic random_config();
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'({$urandom, $urandom});
        if ($urandom_range(0, 4) == 0) data[COUNT_W-1:0] = COUNT_W'($urandom_range(0, 15));
        else data[COUNT_W-1:0] = COUNT_W'($urandom_range(1, NUM_SLOTS));
        cfg_write(CFG_FIELD_COUNT, data);
        data = CFG_DATA_W'({$urandom, $urandom});
        cfg_write(CFG_FIELD_CHANNELS, data);
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if ($urandom_range(0, 3) == 0) data[SIZE_W*k +: SIZE_W] = SIZE_W'($urandom_range(0, 31));
            else data[SIZE_W*k +: SIZE_W] = SIZE_W'($urandom_range(1, CHAN_W));
        end
        cfg_write(CFG_FIELD_SIZES, data);
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: red, 16 bits, one field.
        gap_max = 0;
        send_pixel(make_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        send_pixel(make_pixel(16'h8001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        settle();

        // All channels, all eight fields, width zero and widths above 16.
        gap_max = 19;
        cfg_write(CFG_FIELD_COUNT, CFG_DATA_W'(8));
        cfg_write(CFG_FIELD_CHANNELS, CFG_DATA_W'({CH_ALPHA, CH_BLUE, CH_GREEN, CH_RED,
                                                   CH_ALPHA, CH_BLUE, CH_GREEN, CH_RED}));
        cfg_write(CFG_FIELD_SIZES, {5'd5, 5'd3, 5'd7, 5'd17, 5'd31, 5'd0, 5'd16, 5'd1});
        send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        send_pixel(make_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        send_pixel(make_pixel(16'h8000, 16'h4000, 16'h2000, 16'h1000, 1'b0));
        send_pixel(make_pixel(16'hA5A5, 16'h5A5A, 16'hFFFF, 16'h0001, 1'b1));
        send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        settle();

        // Count zero and width zero: one bit per pixel, most pixels complete no byte.
        cfg_write(CFG_FIELD_COUNT, '0);
        cfg_write(CFG_FIELD_CHANNELS, CFG_DATA_W'(16'hFFFF));
        cfg_write(CFG_FIELD_SIZES, '0);
        for (int i = 0; i < 11; i++)
            send_pixel(make_pixel(random_channel(), random_channel(), random_channel(),
                                  (i % 3 == 0) ? 16'h8000 : 16'h7FFF, 1'b0));
        settle();

        // Count above the slot limit, all widths saturated: a held remainder plus the
        // flush gives the largest burst of bytes from one pixel.
        cfg_write(CFG_FIELD_COUNT, CFG_DATA_W'(15));
        cfg_write(CFG_FIELD_CHANNELS, CFG_DATA_W'({CH_RED, CH_GREEN, CH_BLUE, CH_ALPHA,
                                                   CH_RED, CH_GREEN, CH_BLUE, CH_ALPHA}));
        cfg_write(CFG_FIELD_SIZES, '1);
        send_pixel(random_pixel() | t_pixel'(1));
        send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        settle();

        cfg_write(CFG_FIELD_COUNT, CFG_DATA_W'(1));
        cfg_write(CFG_FIELD_CHANNELS, '0);
        cfg_write(CFG_FIELD_SIZES, CFG_DATA_W'(16));
        send_pixel(make_pixel(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            gap_max = (ph % 3 == 1) ? 0 : 19;
            random_config();
            repeat (PHASE_PIXELS) send_pixel(random_pixel());
            settle();
        end

        if (sb.errors == 0)
            $display("pixel_field_bit_packer regression: pass");
        else
            $display("pixel_field_bit_packer regression: fail");
        $finish;
    end
endmodule

// ===== pixel_field_bit_packer.f =====
+incdir+sv
sv/pfbp_pkg.sv
sv/pfbp_cfg.sv
sv/pfbp_ctrl.sv
sv/pfbp_dpath.sv
sv/pixel_field_bit_packer.sv
sim/tb.sv
